@@ src/mfqs_pkg.sv @@
// ----------------------------------------------------------------------------
// mfqs_pkg
// Shared types and codes for the multilevel feedback queue scheduler.
// ----------------------------------------------------------------------------
package mfqs_pkg;

    // Level index width, fixed by the run_level field
    localparam int LVL_W = 4;

    // Request types
    localparam logic REQ_ADMIT    = 1'b0;
    localparam logic REQ_DISPATCH = 1'b1;

    // Response status codes
    localparam logic [1:0] STAT_ADMITTED   = 2'd0;
    localparam logic [1:0] STAT_REJECTED   = 2'd1;
    localparam logic [1:0] STAT_DISPATCHED = 2'd2;
    localparam logic [1:0] STAT_EMPTY      = 2'd3;

    // Task record as held in the store
    typedef struct packed {
        logic [3:0]  prio;
        logic [9:0]  rem;
        logic [15:0] id;
    } task_rec_t;

    // Queue bookkeeping command from the sequencer
    typedef struct packed {
        logic push;
        logic pop;
        logic live_inc;
        logic live_dec;
    } lvl_cmd_t;

    // Queue bookkeeping status toward the sequencer
    typedef struct packed {
        logic             any_ready;
        logic [LVL_W-1:0] top_lvl;
        logic             sel_full;
        logic             live_full;
    } lvl_stat_t;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ
    } seq_state_t;

endpackage

@@ src/multilevel_feedback_queue_scheduler.sv @@
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler
// Multilevel feedback queue scheduler: admit tasks into priority levels and
// dispatch time slices from the highest nonempty level, demoting survivors.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req_valid/req_ready with req_type, task_id, run_time
//   and priority_req. Each request yields exactly one response on
//   rsp_valid/rsp_ready carrying status and, for a dispatch, the task id,
//   slice length, remaining time, finished flag, level and new priority.
//   Task records live in a single memory of NUM_LEVELS times QUEUE_DEPTH
//   (rounded up to a power of two) entries with registered read data;
//   per-level head and count sit in registers. An admit is accepted, then
//   writes its record and responds; a dispatch is accepted, reads the head
//   record, then writes back a demoted survivor and responds, or responds
//   with no read when nothing is ready. One request is in flight at a time.
//   A response waits in an output register; a new request is taken while it
//   waits, and processing stalls at its final step until the slot frees.
//   Reset clears all level heads, counts and the live task count; the record
//   memory needs no clearing, since only written entries are ever read.
// ----------------------------------------------------------------------------
module multilevel_feedback_queue_scheduler
    import mfqs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int NUM_LEVELS  = 9
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  logic              req_type,
    input  logic [15:0]       task_id,
    input  logic [9:0]        run_time,
    input  logic [3:0]        priority_req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output logic [1:0]        status,
    output logic [15:0]       run_id,
    output logic [9:0]        slice_len,
    output logic signed [10:0] remaining,
    output logic              finished,
    output logic [3:0]        run_level,
    output logic [3:0]        priority_now
);

    localparam int POS_W  = $clog2(QUEUE_DEPTH);
    localparam int LIDX_W = $clog2(NUM_LEVELS);
    localparam int ADDR_W = LIDX_W + POS_W;
    localparam int DEPTH  = NUM_LEVELS << POS_W;

    seq_state_t state_reg, state_next;

    // Captured request
    logic        type_reg;
    logic [15:0] id_reg;
    logic [9:0]  rt_reg;
    logic [3:0]  pr_reg;
    logic [LVL_W-1:0] lvl_reg, lvl_next;

    // Response register
    logic        rsp_valid_reg, rsp_valid_next;
    logic [1:0]  status_reg, status_next;
    logic [15:0] run_id_reg, run_id_next;
    logic [9:0]  slice_reg, slice_next;
    logic [10:0] remaining_reg, remaining_next;
    logic        finished_reg, finished_next;
    logic [3:0]  run_level_reg, run_level_next;
    logic [3:0]  prio_now_reg, prio_now_next;

    // Bookkeeping and memory connections
    lvl_cmd_t         cmd;
    lvl_stat_t        stat;
    logic [LVL_W-1:0] lvl_sel;
    logic [POS_W-1:0] top_head;
    logic [POS_W-1:0] sel_tail;
    logic             wr_en;
    logic [ADDR_W-1:0] wr_addr;
    task_rec_t        wr_data;
    logic             rd_en;
    logic [ADDR_W-1:0] rd_addr;
    task_rec_t        rd_data;

    // Datapath helpers
    logic             out_free;
    logic             pr_ok;
    logic [LVL_W-1:0] adm_lvl;
    logic [LVL_W-1:0] demote_lvl;
    logic [10:0]      slice_full;
    logic signed [11:0] after;
    logic             done;
    logic [3:0]       prio_dec;

    mfqs_levels #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .NUM_LEVELS  (NUM_LEVELS)
    ) u_levels (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .lvl      (lvl_sel),
        .stat     (stat),
        .top_head (top_head),
        .sel_tail (sel_tail)
    );

    mfqs_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free = !rsp_valid_reg || rsp_ready;

    // Admit level from priority; level 0 when priority is invalid
    assign pr_ok   = (pr_reg != 4'd0) && (pr_reg <= 4'(NUM_LEVELS));
    assign adm_lvl = pr_ok ? LVL_W'(4'(NUM_LEVELS) - pr_reg) : '0;

    // Slice arithmetic on the fetched head record
    assign demote_lvl = (lvl_reg == LVL_W'(NUM_LEVELS - 1)) ? lvl_reg
                                                           : lvl_reg + LVL_W'(1);
    assign slice_full = 11'd1 << (lvl_reg + LVL_W'(1));
    assign after      = $signed({2'b00, rd_data.rem}) - $signed({1'b0, slice_full});
    assign done       = after[11] || (after == 12'sd0);
    assign prio_dec   = (rd_data.prio == 4'd0) ? 4'd0 : rd_data.prio - 4'd1;

    // Sequencer: next state, bookkeeping, memory access and response
    always_comb
    begin
        state_next     = state_reg;
        lvl_next       = lvl_reg;
        req_ready      = 1'b0;
        cmd            = '0;
        lvl_sel        = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;
        rd_en          = 1'b0;
        rd_addr        = '0;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        status_next    = status_reg;
        run_id_next    = run_id_reg;
        slice_next     = slice_reg;
        remaining_next = remaining_reg;
        finished_next  = finished_reg;
        run_level_next = run_level_reg;
        prio_now_next  = prio_now_reg;

        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                if (type_reg == REQ_ADMIT)
                begin
                    lvl_sel = adm_lvl;
                    if (out_free)
                    begin
                        rsp_valid_next = 1'b1;
                        run_id_next    = '0;
                        slice_next     = '0;
                        remaining_next = '0;
                        finished_next  = 1'b0;
                        run_level_next = '0;
                        prio_now_next  = '0;
                        if (!pr_ok || stat.live_full || stat.sel_full)
                        begin
                            status_next = STAT_REJECTED;
                        end
                        else
                        begin
                            status_next  = STAT_ADMITTED;
                            wr_en        = 1'b1;
                            wr_addr      = {adm_lvl[LIDX_W-1:0], sel_tail};
                            wr_data      = '{prio: pr_reg, rem: rt_reg, id: id_reg};
                            cmd.push     = 1'b1;
                            cmd.live_inc = 1'b1;
                        end
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    lvl_sel = stat.top_lvl;
                    if (!stat.any_ready)
                    begin
                        if (out_free)
                        begin
                            rsp_valid_next = 1'b1;
                            status_next    = STAT_EMPTY;
                            run_id_next    = '0;
                            slice_next     = '0;
                            remaining_next = '0;
                            finished_next  = 1'b0;
                            run_level_next = '0;
                            prio_now_next  = '0;
                            state_next     = S_IDLE;
                        end
                    end
                    else
                    begin
                        // Fetch and pop the head of the top level
                        rd_en      = 1'b1;
                        rd_addr    = {stat.top_lvl[LIDX_W-1:0], top_head};
                        cmd.pop    = 1'b1;
                        lvl_next   = stat.top_lvl;
                        state_next = S_READ;
                    end
                end
            end

            S_READ:
            begin
                lvl_sel = demote_lvl;
                if (out_free)
                begin
                    if (done)
                    begin
                        cmd.live_dec = 1'b1;
                    end
                    else
                    begin
                        // Demote survivor to the tail of the next level, or of the last level again
                        wr_en    = 1'b1;
                        wr_addr  = {demote_lvl[LIDX_W-1:0], sel_tail};
                        wr_data  = '{prio: prio_dec, rem: after[9:0], id: rd_data.id};
                        cmd.push = 1'b1;
                    end
                    rsp_valid_next = 1'b1;
                    status_next    = STAT_DISPATCHED;
                    run_id_next    = rd_data.id;
                    slice_next     = slice_full[9:0];
                    remaining_next = after[10:0];
                    finished_next  = done;
                    run_level_next = 4'(lvl_reg);
                    prio_now_next  = prio_dec;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            type_reg <= req_type;
            id_reg   <= task_id;
            rt_reg   <= run_time;
            pr_reg   <= priority_req;
        end
        lvl_reg       <= lvl_next;
        status_reg    <= status_next;
        run_id_reg    <= run_id_next;
        slice_reg     <= slice_next;
        remaining_reg <= remaining_next;
        finished_reg  <= finished_next;
        run_level_reg <= run_level_next;
        prio_now_reg  <= prio_now_next;
    end

    assign rsp_valid    = rsp_valid_reg;
    assign status       = status_reg;
    assign run_id       = run_id_reg;
    assign slice_len    = slice_reg;
    assign remaining    = remaining_reg;
    assign finished     = finished_reg;
    assign run_level    = run_level_reg;
    assign priority_now = prio_now_reg;

endmodule

@@ src/mfqs_store.sv @@
// ----------------------------------------------------------------------------
// mfqs_store
// Task record memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mfqs_store
    import mfqs_pkg::*;
#(
    parameter int DEPTH  = 144,
    parameter int ADDR_W = 8
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  task_rec_t         wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output task_rec_t         rd_data
);

    task_rec_t mem [DEPTH];
    task_rec_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/mfqs_levels.sv @@
// ----------------------------------------------------------------------------
// mfqs_levels
// Per-level head and count registers, live task count and the scan for the
// highest-priority nonempty level.
// ----------------------------------------------------------------------------
module mfqs_levels
    import mfqs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int NUM_LEVELS  = 9,
    localparam int POS_W      = $clog2(QUEUE_DEPTH)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  lvl_cmd_t         cmd,
    input  logic [LVL_W-1:0] lvl,
    output lvl_stat_t        stat,
    output logic [POS_W-1:0] top_head,
    output logic [POS_W-1:0] sel_tail
);

    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int LIDX_W = $clog2(NUM_LEVELS);

    logic [POS_W-1:0]  head_reg  [NUM_LEVELS];
    logic [POS_W-1:0]  head_next [NUM_LEVELS];
    logic [CNT_W-1:0]  count_reg [NUM_LEVELS];
    logic [CNT_W-1:0]  count_next[NUM_LEVELS];
    logic [CNT_W-1:0]  live_reg;
    logic [CNT_W-1:0]  live_next;
    logic              any_ready;
    logic [LVL_W-1:0]  top_lvl;
    logic [LIDX_W-1:0] sel_idx;
    logic [CNT_W:0]    tail_sum;

    assign sel_idx = lvl[LIDX_W-1:0];

    // Pick the lowest-numbered nonempty level
    always_comb
    begin
        any_ready = 1'b0;
        top_lvl   = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--)
        begin
            if (count_reg[i] != '0)
            begin
                any_ready = 1'b1;
                top_lvl   = LVL_W'(i);
            end
        end
    end

    assign top_head = head_reg[top_lvl[LIDX_W-1:0]];

    // Tail position of the selected level, wrapped
    always_comb
    begin
        tail_sum = (CNT_W+1)'(head_reg[sel_idx]) + (CNT_W+1)'(count_reg[sel_idx]);
        if (tail_sum >= (CNT_W+1)'(QUEUE_DEPTH))
        begin
            sel_tail = POS_W'(tail_sum - (CNT_W+1)'(QUEUE_DEPTH));
        end
        else
        begin
            sel_tail = POS_W'(tail_sum);
        end
    end

    assign stat.any_ready = any_ready;
    assign stat.top_lvl   = top_lvl;
    assign stat.sel_full  = (count_reg[sel_idx] >= CNT_W'(QUEUE_DEPTH));
    assign stat.live_full = (live_reg >= CNT_W'(QUEUE_DEPTH));

    // Apply push, pop and live count updates
    always_comb
    begin
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            head_next[i]  = head_reg[i];
            count_next[i] = count_reg[i];
        end
        live_next = live_reg;
        if (cmd.push)
        begin
            count_next[sel_idx] = count_reg[sel_idx] + CNT_W'(1);
        end
        if (cmd.pop)
        begin
            count_next[sel_idx] = count_reg[sel_idx] - CNT_W'(1);
            if (head_reg[sel_idx] == POS_W'(QUEUE_DEPTH - 1))
            begin
                head_next[sel_idx] = '0;
            end
            else
            begin
                head_next[sel_idx] = head_reg[sel_idx] + POS_W'(1);
            end
        end
        if (cmd.live_inc)
        begin
            live_next = live_reg + CNT_W'(1);
        end
        else if (cmd.live_dec)
        begin
            live_next = live_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
            live_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                head_reg[i]  <= head_next[i];
                count_reg[i] <= count_next[i];
            end
            live_reg <= live_next;
        end
    end

endmodule

@@ tb/multilevel_feedback_queue_scheduler_tb.sv @@
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler_tb
// Self-checking bench for the multilevel feedback queue scheduler. A
// behavioral copy of the nine ready levels tracks every admit and dispatch
// request and predicts the response. A monitor compares each response with
// the oldest prediction. Directed tests cover rejects, the empty scheduler,
// zero run time and the last level. A fill test runs under long response
// backpressure, then random traffic with idle bursts, then full rate.
// ----------------------------------------------------------------------------
module multilevel_feedback_queue_scheduler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mfqs_pkg::*;

    localparam int QUEUE_DEPTH  = 16;
    localparam int NUM_LEVELS   = 9;
    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 9;
    localparam int SETTLE_CYCLES = 10;
    localparam int HOLD_CYCLES  = 400;

    // Expected response, laid out in port order
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] run_id;
        logic [9:0]  slice_len;
        logic [10:0] remaining;
        logic        finished;
        logic [3:0]  run_level;
        logic [3:0]  priority_now;
    } sched_rsp_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        req_valid    = 1'b0;
    logic        req_ready;
    logic        req_type     = REQ_ADMIT;
    logic [15:0] task_id      = '0;
    logic [9:0]  run_time     = '0;
    logic [3:0]  priority_req = '0;
    logic        rsp_valid;
    logic        rsp_ready    = 1'b0;
    logic [1:0]  status;
    logic [15:0] run_id;
    logic [9:0]  slice_len;
    logic signed [10:0] remaining;
    logic        finished;
    logic [3:0]  run_level;
    logic [3:0]  priority_now;

    // Shadow scheduler state
    task_rec_t   level_fifo [NUM_LEVELS][$];
    int unsigned live_count  = 0;
    sched_rsp_t  pending_rsp [$];

    int unsigned mismatch_cnt    = 0;
    bit          bursts_on       = 1'b1;
    int unsigned rsp_hold_cycles = 0;

    multilevel_feedback_queue_scheduler #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .NUM_LEVELS  (NUM_LEVELS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req_type     (req_type),
        .task_id      (task_id),
        .run_time     (run_time),
        .priority_req (priority_req),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .status       (status),
        .run_id       (run_id),
        .slice_len    (slice_len),
        .remaining    (remaining),
        .finished     (finished),
        .run_level    (run_level),
        .priority_now (priority_now)
    );

    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // Advance the shadow levels by one request and return its response
    function automatic sched_rsp_t schedule_request(logic kind, logic [15:0] id,
                                                    logic [9:0] rt, logic [3:0] pr);
        sched_rsp_t rsp;
        task_rec_t  rec;
        int         lvl;
        int         slice;
        int         after;
        int         next_lvl;
        rsp = '0;
        lvl = -1;
        if (kind == REQ_ADMIT)
        begin
            if (pr == 0 || pr > NUM_LEVELS || live_count >= QUEUE_DEPTH)
                rsp.status = STAT_REJECTED;
            else
            begin
                rec.id   = id;
                rec.rem  = rt;
                rec.prio = pr;
                level_fifo[NUM_LEVELS - pr].push_back(rec);
                live_count++;
                rsp.status = STAT_ADMITTED;
            end
        end
        else
        begin
            // pick the highest nonempty level
            for (int k = 0; k < NUM_LEVELS; k++)
                if (lvl < 0 && level_fifo[k].size() != 0)
                    lvl = k;
            if (lvl < 0)
                rsp.status = STAT_EMPTY;
            else
            begin
                rec   = level_fifo[lvl].pop_front();
                slice = 1 << (lvl + 1);
                after = int'(rec.rem) - slice;
                if (rec.prio != 0)
                    rec.prio = rec.prio - 4'd1;
                rsp.status       = STAT_DISPATCHED;
                rsp.run_id       = rec.id;
                rsp.slice_len    = slice[9:0];
                rsp.remaining    = after[10:0];
                rsp.finished     = (after <= 0);
                rsp.run_level    = lvl[3:0];
                rsp.priority_now = rec.prio;
                // drop a finished task, demote the rest (last level keeps it)
                if (after <= 0)
                    live_count--;
                else
                begin
                    next_lvl = (lvl + 1 < NUM_LEVELS) ? lvl + 1 : lvl;
                    rec.rem  = after[9:0];
                    level_fifo[next_lvl].push_back(rec);
                end
            end
        end
        return rsp;
    endfunction

    // Offer one request, hold it until accepted, then log its prediction
    task automatic send_request(input logic kind, input logic [15:0] id,
                                input logic [9:0] rt, input logic [3:0] pr);
        if (bursts_on && $urandom_range(0, 5) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        req_valid    <= 1'b1;
        req_type     <= kind;
        task_id      <= id;
        run_time     <= rt;
        priority_req <= pr;
        do
            @(posedge clk);
        while (!req_ready);
        pending_rsp.push_back(schedule_request(kind, id, rt, pr));
    endtask

    task automatic send_dispatch();
        send_request(REQ_DISPATCH, 16'($urandom), 10'($urandom), 4'($urandom));
    endtask

    // Mostly well-formed admits and dispatches, a few bad priorities
    task automatic send_random_request();
        logic       kind;
        logic [9:0] rt;
        logic [3:0] pr;
        kind = ($urandom_range(0, 99) < 55) ? REQ_DISPATCH : REQ_ADMIT;
        if ($urandom_range(0, 9) == 0)
            pr = 4'($urandom_range(0, 15));
        else
            pr = 4'($urandom_range(1, NUM_LEVELS));
        if ($urandom_range(0, 1) == 0)
            rt = 10'($urandom_range(0, 40));
        else
            rt = 10'($urandom_range(0, 1023));
        send_request(kind, 16'($urandom), rt, pr);
    endtask

    // Drop valid and hold off until every outstanding response is back
    task automatic wait_drained();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_rsp.size() != 0);
    endtask

    // Dispatch until the shadow scheduler holds no task
    task automatic flush_tasks();
        while (live_count != 0)
            send_dispatch();
    endtask

    task automatic test_empty_dispatch();
        send_dispatch();
        wait_drained();
    endtask

    // Bad priorities, zero run time, extreme ids
    task automatic test_admit_edges();
        send_request(REQ_ADMIT, 16'h1234, 10'd5, 4'd0);
        send_request(REQ_ADMIT, 16'h1235, 10'd5, 4'd10);
        send_request(REQ_ADMIT, 16'h1236, 10'd5, 4'd15);
        send_request(REQ_ADMIT, 16'h0000, 10'd0, 4'd1);
        send_dispatch();
        send_request(REQ_ADMIT, 16'h5A5A, 10'd1, 4'd8);
        send_dispatch();
        send_dispatch();
        wait_drained();
    endtask

    // Longest task walks every level, revisits the last one and overruns there
    task automatic test_last_level();
        send_request(REQ_ADMIT, 16'hFFFF, 10'd1023, 4'd9);
        repeat (NUM_LEVELS + 1) send_dispatch();
        wait_drained();
    endtask

    // Overfill the scheduler while responses are held back
    task automatic test_fill_under_backpressure();
        flush_tasks();
        rsp_hold_cycles = HOLD_CYCLES;
        repeat (QUEUE_DEPTH + 4)
            send_request(REQ_ADMIT, 16'($urandom), 10'($urandom),
                         4'($urandom_range(1, NUM_LEVELS)));
        flush_tasks();
        send_dispatch();
        wait_drained();
    endtask

    task automatic test_random_mix(input int unsigned count);
        for (int unsigned n = 1; n <= count; n++)
        begin
            send_random_request();
            if (n % 300 == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    task automatic test_full_rate(input int unsigned count);
        bursts_on = 1'b0;
        repeat (count) send_random_request();
        flush_tasks();
        wait_drained();
    endtask

    // Drive response ready: random stall bursts and the long hold-off
    initial
    begin
        int unsigned hold;
        forever
        begin
            @(posedge clk);
            if (rsp_hold_cycles != 0)
            begin
                hold = rsp_hold_cycles;
                rsp_hold_cycles = 0;
                rsp_ready <= 1'b0;
                repeat (hold) @(posedge clk);
                rsp_ready <= 1'b1;
            end
            else if (bursts_on && $urandom_range(0, 9) == 0)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                rsp_ready <= 1'b1;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    // Check each accepted response against the oldest prediction
    always @(posedge clk)
    begin
        sched_rsp_t got;
        sched_rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            got = {status, run_id, slice_len, remaining, finished, run_level, priority_now};
            if (pending_rsp.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("%t: response with no request outstanding: st=%0d id=%h",
                             $realtime, status, run_id);
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (got !== want)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                    begin
                        $display("%t: mismatch exp st=%0d id=%h slice=%0d rem=%0d fin=%b lvl=%0d pri=%0d",
                                 $realtime, want.status, want.run_id, want.slice_len,
                                 $signed(want.remaining), want.finished, want.run_level,
                                 want.priority_now);
                        $display("%t:          got st=%0d id=%h slice=%0d rem=%0d fin=%b lvl=%0d pri=%0d",
                                 $realtime, got.status, got.run_id, got.slice_len,
                                 $signed(got.remaining), got.finished, got.run_level,
                                 got.priority_now);
                    end
                end
            end
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_dispatch();
        test_admit_edges();
        test_last_level();
        test_fill_under_backpressure();
        test_random_mix(1500);
        test_full_rate(400);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0 && pending_rsp.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ multilevel_feedback_queue_scheduler.f @@
src/mfqs_pkg.sv
src/mfqs_store.sv
src/mfqs_levels.sv
src/multilevel_feedback_queue_scheduler.sv
tb/multilevel_feedback_queue_scheduler_tb.sv
